>>> rtl/core/pdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdb_pkg;

   localparam int COORD_BITS_DEF = 15;
   localparam int DIST_BITS      = 16;
   localparam int BEAR_BITS      = 9;
   localparam int OCT_BITS       = 6;
   localparam int OCT_LAST       = 44;
   localparam int TAN_FRAC       = 48;
   localparam int TAN_DEPTH      = 1 << OCT_BITS;

   typedef enum logic [2:0] {
      MODE_ZERO,
      MODE_AXIS,
      MODE_DIAG,
      MODE_LOW,
      MODE_HIGH
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  quad;
   } ctl_type;

   typedef logic [TAN_FRAC-1:0] tan_lut_type [TAN_DEPTH];

   // tan(d deg) in unsigned Q0.48; entries past the octant are never used
   function automatic tan_lut_type build_tan();
      tan_lut_type t;
      real         r;
      for (int d = 0; d < TAN_DEPTH; d++) begin
         if (d <= OCT_LAST) begin
            r    = $tan(real'(d) * 3.14159265358979323846 / 180.0) * (2.0 ** TAN_FRAC);
            t[d] = TAN_FRAC'(longint'(r));
         end else begin
            t[d] = '0;
         end
      end
      return t;
   endfunction

   localparam tan_lut_type TAN_LUT = build_tan();

endpackage
`default_nettype wire

>>> rtl/core/pdb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pdb_front #(
   parameter int CB = pdb_pkg::COORD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [CB-1:0]     x1,
   input  wire logic [CB-1:0]     y1,
   input  wire logic [CB-1:0]     x2,
   input  wire logic [CB-1:0]     y2,
   output logic                   out_valid,
   output logic [2*CB:0]          out_sq,
   output logic [CB-1:0]          out_u,
   output logic [CB-1:0]          out_v,
   output pdb_pkg::ctl_type       out_ctl
);
   import pdb_pkg::*;

   logic signed [CB:0] ax, ay, nax, nay;
   logic [CB-1:0]      u, v, uu, vv;
   ctl_type            ctl;
   logic [2*CB:0]      sq;

   logic               valid_ff, valid_in;
   logic [2*CB:0]      sq_ff;
   logic [CB-1:0]      u_ff, v_ff;
   ctl_type            ctl_ff;

   always_comb begin
      ax  = $signed({1'b0, x2}) - $signed({1'b0, x1});
      ay  = $signed({1'b0, y1}) - $signed({1'b0, y2});
      nax = -ax;
      nay = -ay;
      ctl.quad = 2'd0;
      u = '0;
      v = '0;
      if (ax > 0 && ay >= 0) begin
         ctl.quad = 2'd0; u = ax[CB-1:0];  v = ay[CB-1:0];
      end else if (ax <= 0 && ay > 0) begin
         ctl.quad = 2'd1; u = ay[CB-1:0];  v = nax[CB-1:0];
      end else if (ax < 0 && ay <= 0) begin
         ctl.quad = 2'd2; u = nax[CB-1:0]; v = nay[CB-1:0];
      end else begin
         ctl.quad = 2'd3; u = nay[CB-1:0]; v = ax[CB-1:0];
      end
      uu = u;
      vv = v;
      if (ax == 0 && ay == 0) begin
         ctl.mode = MODE_ZERO;
      end else if (v == '0) begin
         ctl.mode = MODE_AXIS;
      end else if (v == u) begin
         ctl.mode = MODE_DIAG;
      end else if (v < u) begin
         ctl.mode = MODE_LOW;
      end else begin
         ctl.mode = MODE_HIGH;
         uu = v;
         vv = u;
      end
      sq = (2*CB+1)'({CB'(0), u} * {CB'(0), u}) + (2*CB+1)'({CB'(0), v} * {CB'(0), v});
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff  <= sq;
      u_ff   <= uu;
      v_ff   <= vv;
      ctl_ff <= ctl;
   end

   assign out_valid = valid_ff;
   assign out_sq    = sq_ff;
   assign out_u     = u_ff;
   assign out_v     = v_ff;
   assign out_ctl   = ctl_ff;

endmodule
`default_nettype wire

>>> rtl/core/pdb_step.sv
`timescale 1ns / 1ps
`default_nettype none
module pdb_step #(
   parameter int CB  = pdb_pkg::COORD_BITS_DEF,
   parameter int IDX = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [2*CB:0]                 in_rem,
   input  wire logic [CB:0]                   in_root,
   input  wire logic [CB-1:0]                 in_u,
   input  wire logic [CB-1:0]                 in_v,
   input  wire logic [pdb_pkg::OCT_BITS-1:0]  in_k,
   input  wire pdb_pkg::ctl_type              in_ctl,
   output logic                               out_valid,
   output logic [2*CB:0]                      out_rem,
   output logic [CB:0]                        out_root,
   output logic [CB-1:0]                      out_u,
   output logic [CB-1:0]                      out_v,
   output logic [pdb_pkg::OCT_BITS-1:0]       out_k,
   output pdb_pkg::ctl_type                   out_ctl
);
   import pdb_pkg::*;

   localparam int DB = CB + 1;
   localparam int SB = 2 * CB + 1;
   localparam int TW = SB + 2;
   localparam int PW = CB + TAN_FRAC;
   localparam int BI = (IDX < DB) ? (DB - 1 - IDX) : 0;
   localparam int KB = (IDX < OCT_BITS) ? (OCT_BITS - 1 - IDX) : 0;

   logic [TW-1:0]       trial;
   logic [SB-1:0]       rem_in;
   logic [DB-1:0]       root_in;
   logic [OCT_BITS-1:0] cand, k_in;
   logic [PW-1:0]       lhs, rhs;

   logic                valid_ff;
   logic [SB-1:0]       rem_ff;
   logic [DB-1:0]       root_ff;
   logic [CB-1:0]       u_ff, v_ff;
   logic [OCT_BITS-1:0] k_ff;
   ctl_type             ctl_ff;

   // sqrt: one root bit; atan: one bit of binary search over tan(d)
   always_comb begin
      trial   = (TW'(in_root) << (BI + 1)) | (TW'(1) << (2 * BI));
      rem_in  = in_rem;
      root_in = in_root;
      if (IDX < DB && {2'b00, in_rem} >= trial) begin
         rem_in  = SB'({2'b00, in_rem} - trial);
         root_in = in_root | (DB'(1) << BI);
      end
      cand = in_k | (OCT_BITS'(1) << KB);
      lhs  = {in_v, TAN_FRAC'(0)};
      rhs  = PW'(in_u) * PW'(TAN_LUT[cand]);
      k_in = in_k;
      if (IDX < OCT_BITS && cand <= OCT_BITS'(OCT_LAST) && lhs >= rhs) begin
         k_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      u_ff    <= in_u;
      v_ff    <= in_v;
      k_ff    <= k_in;
      ctl_ff  <= in_ctl;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_u     = u_ff;
   assign out_v     = v_ff;
   assign out_k     = k_ff;
   assign out_ctl   = ctl_ff;

endmodule
`default_nettype wire

>>> rtl/core/point_distance_and_bearing.sv
// Distance and bearing between two map points. One item enters per clock
// (busy stays low) and its result appears on rsp_* with rsp_valid high for
// one cycle. It passes one stage that folds the vector and squares it,
// max(COORD_BITS + 1, 6) stages, of which the first COORD_BITS + 1 each
// settle one square-root bit and the first OCT_BITS each one step of the
// binary search over tan(degree), and one stage that forms the bearing.
// The receiver cannot stall the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module point_distance_and_bearing #(
   parameter int COORD_BITS = pdb_pkg::COORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [COORD_BITS-1:0]           req_first_x,
   input  wire logic [COORD_BITS-1:0]           req_first_y,
   input  wire logic [COORD_BITS-1:0]           req_second_x,
   input  wire logic [COORD_BITS-1:0]           req_second_y,
   output logic                                 rsp_valid,
   output logic [pdb_pkg::DIST_BITS-1:0]        rsp_distance,
   output logic [pdb_pkg::BEAR_BITS-1:0]        rsp_bearing_deg
);
   import pdb_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DB = CB + 1;
   localparam int SB = 2 * CB + 1;
   localparam int NS = (DB > OCT_BITS) ? DB : OCT_BITS;

   logic                valid_s [NS+1];
   logic [SB-1:0]       rem_s   [NS+1];
   logic [DB-1:0]       root_s  [NS+1];
   logic [CB-1:0]       u_s     [NS+1];
   logic [CB-1:0]       v_s     [NS+1];
   logic [OCT_BITS-1:0] k_s     [NS+1];
   ctl_type             ctl_s   [NS+1];

   logic [BEAR_BITS-1:0] base, bear_in;
   logic                 valid_ff;
   logic [DIST_BITS-1:0] dist_ff;
   logic [BEAR_BITS-1:0] bear_ff;

   assign busy      = 1'b0;
   assign root_s[0] = '0;
   assign k_s[0]    = '0;

   pdb_front #(.CB(CB)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .x1        (req_first_x),
      .y1        (req_first_y),
      .x2        (req_second_x),
      .y2        (req_second_y),
      .out_valid (valid_s[0]),
      .out_sq    (rem_s[0]),
      .out_u     (u_s[0]),
      .out_v     (v_s[0]),
      .out_ctl   (ctl_s[0])
   );

   for (genvar i = 0; i < NS; i++) begin : g_step
      pdb_step #(.CB(CB), .IDX(i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[i]),
         .in_rem    (rem_s[i]),
         .in_root   (root_s[i]),
         .in_u      (u_s[i]),
         .in_v      (v_s[i]),
         .in_k      (k_s[i]),
         .in_ctl    (ctl_s[i]),
         .out_valid (valid_s[i+1]),
         .out_rem   (rem_s[i+1]),
         .out_root  (root_s[i+1]),
         .out_u     (u_s[i+1]),
         .out_v     (v_s[i+1]),
         .out_k     (k_s[i+1]),
         .out_ctl   (ctl_s[i+1])
      );
   end

   always_comb begin
      base = BEAR_BITS'(ctl_s[NS].quad) * BEAR_BITS'(90);
      unique case (ctl_s[NS].mode)
         MODE_ZERO: bear_in = '0;
         MODE_AXIS: bear_in = base;
         MODE_DIAG: bear_in = base + BEAR_BITS'(45);
         MODE_LOW:  bear_in = base + BEAR_BITS'(k_s[NS]);
         MODE_HIGH: bear_in = base + BEAR_BITS'(89) - BEAR_BITS'(k_s[NS]);
         default:   bear_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_s[NS];
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= DIST_BITS'(root_s[NS]);
      bear_ff <= bear_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_bearing_deg = bear_ff;

endmodule
`default_nettype wire
